/* src/assert_macros.svh */
// Assertion helpers shared by the RTL; clocked on clk, quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMP(lbl, ante, cons, msg)
`define AST_NXT(lbl, ante, cons, msg)
`endif
`endif

/* src/ole_pkg.sv */
`timescale 1ns / 1ps
package ole_pkg;

  localparam int CAPACITY = 64;
  localparam int ITEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int GRP_N    = (CAPACITY + 7) / 8;
  localparam int GRP_IW   = (GRP_N > 1) ? $clog2(GRP_N) : 1;

  typedef logic signed [ITEM_W-1:0] item_t;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_DEL_AT = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic             push;
    logic             del;
    logic [POS_W-1:0] del_pos;
    item_t            key;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] idx;
  } find_sel_t;

endpackage

/* src/ordered_list_engine_top.sv */
`timescale 1ns / 1ps
// Ordered list engine: bounded list kept in a chain of cells, head in cell 0.
// Steps: at the accepting edge the cells latch their compare bits; ole_find
// then registers the group pick, and the final pick loads the result word
// and raises out_valid. The find path (cell compare, group pick, final pick)
// sets the pace; busy stays high until the result is loaded, so no new word
// is taken before the result is out.
// Reset (rst_n low, synchronous) empties the list and clears the strobe.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module ordered_list_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_value,
  input  logic [5:0]         in_position,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [5:0]         out_found_index,
  output logic [6:0]         out_count,
  output logic               out_is_empty,
  output logic signed [31:0] out_head_value
);
  import ole_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [1:0] {S_IDLE, S_GRP, S_FIN} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  act_t             op_r, op_nxt;
  status_t          status_r, status_nxt;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic             out_found_r;
  logic [5:0]       out_found_index_r;
  logic [6:0]       out_count_r;
  logic             out_is_empty_r;
  logic signed [31:0] out_head_value_r;

  logic          accept;
  act_t          act;
  item_t         key;
  cell_ctrl_t    ctrl;
  item_t         cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  find_sel_t     fsel;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign act    = act_t'(in_action);
  // Stored items are ITEM_W wide: sign-extend or cut the 32-bit word.
  assign key    = ITEM_W'(in_value);

  // Decode the word, flag illegal requests and steer the shift of the chain.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    op_nxt       = op_r;
    status_nxt   = status_r;
    ctrl.push    = 1'b0;
    ctrl.del     = 1'b0;
    ctrl.del_pos = '0;
    ctrl.key     = key;
    ctrl.count   = count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_GRP;
          op_nxt     = act;
          status_nxt = ST_OK;
          case (act)
            ACT_PUSH: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                ctrl.push = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                ctrl.del  = 1'b1;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ACT_FIND: begin
              // cells latch their compare bits on this edge
            end
            ACT_DEL_AT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (32'(in_position) >= 32'(count_r)) begin
                status_nxt = ST_RANGE;
              end else begin
                ctrl.del     = 1'b1;
                ctrl.del_pos = in_position;
                count_nxt    = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_GRP:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // The chain: each cell takes its left neighbor on push, its right neighbor
  // on delete at or behind the hole. Cell 0 takes the new word; the tail
  // holds its own value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    item_t left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = key;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = cell_val[i];
    end else begin : g_body
      assign right_v = cell_val[i+1];
    end
    ole_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctrl      (ctrl),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i]),
      .hit       (cell_hit[i])
    );
  end

  ole_find u_find (
    .clk  (clk),
    .hits (cell_hit),
    .sel  (fsel)
  );

  // State, count and the result word; the result is loaded on the last
  // step and held on the ports until the next result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_FIN);
    end
    op_r     <= op_nxt;
    status_r <= status_nxt;
    if (state_r == S_FIN) begin
      out_status_r      <= status_r;
      out_found_r       <= (op_r == ACT_FIND) && fsel.any;
      out_found_index_r <= ((op_r == ACT_FIND) && fsel.any) ? 6'(fsel.idx) : 6'd0;
      out_count_r       <= 7'(count_r);
      out_is_empty_r    <= (count_r == '0);
      out_head_value_r  <= (count_r != '0) ? 32'(cell_val[0]) : 32'sd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_found_index_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_head_value  = out_head_value_r;

  `AST_IMP(a_cnt_max, 1'b1, count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `AST_NXT(a_busy, accept, busy, "busy not raised after accept")
  `AST_NXT(a_strobe, state_r == S_FIN, out_valid, "result strobe missing")
  `AST_IMP(a_strobe_src, out_valid, $past(state_r) == S_FIN, "stray result strobe")
  `AST_NXT(a_cnt_hold, !accept, $stable(count_r), "count moved without a word")

endmodule

/* src/ole_cell.sv */
`timescale 1ns / 1ps
module ole_cell (
  input  logic                     clk,
  input  logic [ole_pkg::IDX_W-1:0] idx,
  input  ole_pkg::cell_ctrl_t      ctrl,
  input  ole_pkg::item_t           left_val,
  input  ole_pkg::item_t           right_val,
  output ole_pkg::item_t           val,
  output logic                     hit
);
  import ole_pkg::*;

  item_t val_r, val_nxt;
  logic  hit_r, hit_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.push) begin
      val_nxt = left_val;
    end else if (ctrl.del && (32'(idx) >= 32'(ctrl.del_pos))) begin
      val_nxt = right_val;
    end
    hit_nxt = (val_r == ctrl.key) && (32'(idx) < 32'(ctrl.count));
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hit_r <= hit_nxt;
  end

  assign val = val_r;
  assign hit = hit_r;

endmodule

/* src/ole_find.sv */
`timescale 1ns / 1ps
module ole_find (
  input  logic                         clk,
  input  logic [ole_pkg::CAPACITY-1:0] hits,
  output ole_pkg::find_sel_t           sel
);
  import ole_pkg::*;

  logic [GRP_N*8-1:0] hit_pad;
  logic [GRP_N-1:0]   grp_any_r;
  logic [2:0]         grp_loc_r [GRP_N];
  logic [GRP_IW-1:0]  grp_sel;

  function automatic logic [2:0] low8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  assign hit_pad = (GRP_N*8)'(hits);

  // first level: one priority pick per group of eight cells
  always_ff @(posedge clk) begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any_r[g] <= |hit_pad[g*8 +: 8];
      grp_loc_r[g] <= low8(hit_pad[g*8 +: 8]);
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any_r[g]) grp_sel = GRP_IW'(g);
    end
    sel.any = |grp_any_r;
    sel.idx = IDX_W'({grp_sel, grp_loc_r[grp_sel]});
  end

endmodule
